// ----- hdl/apsc_pkg.sv -----
// apsc_pkg: shared types, constants and helpers for the actuator position sense conditioner
// used by apsc_div and actuator_position_sense_conditioner; no dependencies
`timescale 1ns / 1ps

package apsc_pkg;

  localparam int ADC_BITS            = 12;
  localparam int SAMPLES_PER_AVERAGE = 10;
  localparam int SUM_W               = 16;
  localparam int CNT_W               = 4;
  localparam int PCT_W               = 7;
  localparam int DIV_W               = 20;   // signed dividend / quotient width
  localparam int DEN_W               = ADC_BITS + 1;  // signed divisor width
  localparam int DIV_CNT_W           = $clog2(DIV_W);
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 12;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  localparam logic [ADC_BITS-1:0] RST_POT_ADC_LOW    = '0;
  localparam logic [ADC_BITS-1:0] RST_POT_ADC_HIGH   = '1;
  localparam logic [PCT_W-1:0]    RST_WIN_LOW        = '0;
  localparam logic [PCT_W-1:0]    RST_WIN_HIGH       = PCT_W'(100);
  localparam logic [ADC_BITS-1:0] RST_CURRENT_LIMIT  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POT_ADC_LOW      = 3'd0,
    REG_POT_ADC_HIGH     = 3'd1,
    REG_POT_REVERSED     = 3'd2,
    REG_WIN_LOW_PCT      = 3'd3,
    REG_WIN_HIGH_PCT     = 3'd4,
    REG_CURRENT_LIMIT    = 3'd5,
    REG_ESTOP_LOW_ACTIVE = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG,
    ST_MAP1_GO,
    ST_MAP1,
    ST_MAP2_GO,
    ST_MAP2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;  // two's complement
    logic [DEN_W-1:0] divisor;   // two's complement, nonzero
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;  // two's complement, truncated toward zero
  } div_rsp_t;

  // x * 100 as shift-and-add
  function automatic logic signed [DIV_W-1:0] mul100(input logic signed [DIV_W-1:0] v);
    return (v <<< 6) + (v <<< 5) + (v <<< 2);
  endfunction

  // clamp a signed quotient to 0..100
  function automatic logic [PCT_W-1:0] clamp_pct(input logic signed [DIV_W-1:0] v);
    logic [PCT_W-1:0] res;
    if (v[DIV_W-1]) begin
      res = '0;
    end else if (v > $signed({{(DIV_W-PCT_W){1'b0}}, PCT_FULL})) begin
      res = PCT_FULL;
    end else begin
      res = v[PCT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/apsc_div.sv -----
// apsc_div: bit-serial restoring signed divider, one quotient bit per cycle
// depends on apsc_pkg
`timescale 1ns / 1ps

module apsc_div
  import apsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DEN_W-2:0]     rem_r, rem_nxt;
  logic [DEN_W-2:0]     dmag_r, dmag_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;

  logic [DEN_W-1:0]     shifted;
  logic [DEN_W-1:0]     trial;
  logic                 ge;
  logic [DIV_W-1:0]     q_step;
  logic [DIV_W-1:0]     nd_abs;
  logic [DEN_W-1:0]     dv_abs;

  always_comb begin
    nd_abs   = req.dividend[DIV_W-1] ? (~req.dividend + DIV_W'(1)) : req.dividend;
    dv_abs   = req.divisor[DEN_W-1] ? (~req.divisor + DEN_W'(1)) : req.divisor;
    shifted  = {rem_r, q_r[DIV_W-1]};
    trial    = shifted - {1'b0, dmag_r};
    ge       = (shifted >= {1'b0, dmag_r});
    q_step   = {q_r[DIV_W-2:0], ge};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = nd_abs;
      rem_nxt  = '0;
      dmag_nxt = dv_abs[DEN_W-2:0];
      neg_nxt  = req.dividend[DIV_W-1] ^ req.divisor[DEN_W-1];
    end else if (busy_r) begin
      q_nxt   = q_step;
      rem_nxt = ge ? trial[DEN_W-2:0] : shifted[DEN_W-2:0];
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quo_nxt  = neg_r ? (~q_step + DIV_W'(1)) : q_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    quo_r  <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- hdl/actuator_position_sense_conditioner.sv -----
// actuator_position_sense_conditioner: top level, sequencer, config registers, result register
// depends on apsc_pkg and apsc_div
`timescale 1ns / 1ps

// Conditions window actuator sensing. Pot items (action 0) add into a running
// sum; every tenth pot item closes the group and, if the motor is moving and
// both ranges are nonzero, the truncated average is mapped onto 0..100 percent
// (forward or reversed), clamped, remapped through the window limits, clamped
// again and taken as the new position when it moves by more than 1. Status
// items (action 1) set the emergency stop flag from the pin and its polarity
// and latch overcurrent on either current sample above the limit; only reset
// clears that latch. Every input item yields exactly one result item carrying
// the held position and both flags. An item that does not close a mapped
// group goes from ST_IDLE through ST_EMIT to the result register; a mapped
// one goes through the AVG, MAP1 and MAP2 states (each a _GO state then a
// wait) and ST_EMIT, passing three times through the one bit-serial divider
// (average, pot map, window map). Items are taken only in ST_IDLE, also while
// the last result waits in the output register. Configuration writes take
// effect at once and are meant to be made while the block is idle.

module actuator_position_sense_conditioner
  import apsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [ADC_BITS-1:0]   in_pot_sample,
  input  logic                  in_motor_moving,
  input  logic [ADC_BITS-1:0]   in_right_current_sample,
  input  logic [ADC_BITS-1:0]   in_left_current_sample,
  input  logic                  in_estop_pin,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PCT_W-1:0]      out_position_percent,
  output logic                  out_estop_pressed,
  output logic                  out_overcurrent
);

  // configuration registers
  logic [ADC_BITS-1:0] pot_adc_low_r;
  logic [ADC_BITS-1:0] pot_adc_high_r;
  logic                pot_reversed_r;
  logic [PCT_W-1:0]    win_low_r;
  logic [PCT_W-1:0]    win_high_r;
  logic [ADC_BITS-1:0] current_limit_r;
  logic                estop_low_active_r;

  // block state
  state_t              state_r, state_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PCT_W-1:0]    held_r, held_nxt;
  logic                estop_r, estop_nxt;
  logic                oc_r, oc_nxt;

  // divider operands, loaded one state ahead of each start
  logic [DIV_W-1:0]    num_r, num_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0]    out_pos_r;
  logic                out_estop_r;
  logic                out_oc_r;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                in_acc;
  logic                emit_load;
  logic                group_done;
  logic                map_ok;
  logic [SUM_W-1:0]    sum_new;
  logic [ADC_BITS-1:0] map_a;
  logic [ADC_BITS-1:0] map_b;
  logic [ADC_BITS-1:0] avg;
  logic [DEN_W-1:0]    avg_off;
  logic [PCT_W-1:0]    phys;
  logic [PCT_W-1:0]    disp;
  logic [PCT_W:0]      phys_off;
  logic [PCT_W:0]      win_span;
  logic signed [PCT_W:0] move;

  apsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_adc_low_r      <= RST_POT_ADC_LOW;
      pot_adc_high_r     <= RST_POT_ADC_HIGH;
      pot_reversed_r     <= 1'b0;
      win_low_r          <= RST_WIN_LOW;
      win_high_r         <= RST_WIN_HIGH;
      current_limit_r    <= RST_CURRENT_LIMIT;
      estop_low_active_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_POT_ADC_LOW:      pot_adc_low_r      <= cfg_wdata[ADC_BITS-1:0];
        REG_POT_ADC_HIGH:     pot_adc_high_r     <= cfg_wdata[ADC_BITS-1:0];
        REG_POT_REVERSED:     pot_reversed_r     <= cfg_wdata[0];
        REG_WIN_LOW_PCT:      win_low_r          <= cfg_wdata[PCT_W-1:0];
        REG_WIN_HIGH_PCT:     win_high_r         <= cfg_wdata[PCT_W-1:0];
        REG_CURRENT_LIMIT:    current_limit_r    <= cfg_wdata[ADC_BITS-1:0];
        REG_ESTOP_LOW_ACTIVE: estop_low_active_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // item classification
  always_comb begin
    in_acc     = in_valid && in_ready;
    sum_new    = sum_r + SUM_W'(in_pot_sample);
    group_done = ({1'b0, cnt_r} + (CNT_W+1)'(1)) >= (CNT_W+1)'(SAMPLES_PER_AVERAGE);
    // a group is mapped only while moving and with both ranges nonzero
    map_ok     = in_motor_moving && (pot_adc_low_r != pot_adc_high_r)
                 && (win_low_r != win_high_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_action && group_done && map_ok) begin
            state_nxt = ST_AVG_GO;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_AVG_GO:  state_nxt = ST_AVG;
      ST_AVG:     if (div_rsp.done) state_nxt = ST_MAP1_GO;
      ST_MAP1_GO: state_nxt = ST_MAP1;
      ST_MAP1:    if (div_rsp.done) state_nxt = ST_MAP2_GO;
      ST_MAP2_GO: state_nxt = ST_MAP2;
      ST_MAP2:    if (div_rsp.done) state_nxt = ST_EMIT;
      ST_EMIT:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    emit_load        = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
    div_req.start    = (state_r == ST_AVG_GO) || (state_r == ST_MAP1_GO)
                       || (state_r == ST_MAP2_GO);
    div_req.dividend = num_r;
    div_req.divisor  = den_r;
  end

  // datapath
  always_comb begin
    // reversed swaps the ends of the pot map
    map_a    = pot_reversed_r ? pot_adc_high_r : pot_adc_low_r;
    map_b    = pot_reversed_r ? pot_adc_low_r : pot_adc_high_r;
    avg      = div_rsp.quotient[ADC_BITS-1:0];
    avg_off  = {1'b0, avg} - {1'b0, map_a};
    phys     = clamp_pct($signed(div_rsp.quotient));
    phys_off = {1'b0, phys} - {1'b0, win_low_r};
    win_span = {1'b0, win_high_r} - {1'b0, win_low_r};
    disp     = clamp_pct($signed(div_rsp.quotient));
    move     = $signed({1'b0, disp}) - $signed({1'b0, held_r});

    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    estop_nxt = estop_r;
    oc_nxt    = oc_r;
    num_nxt   = num_r;
    den_nxt   = den_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_action) begin
            // pot samples accumulate whether or not the motor moves
            if (group_done) begin
              sum_nxt = '0;
              cnt_nxt = '0;
              num_nxt = DIV_W'(sum_new);
              den_nxt = DEN_W'(SAMPLES_PER_AVERAGE);
            end else begin
              sum_nxt = sum_new;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            estop_nxt = estop_low_active_r ? ~in_estop_pin : in_estop_pin;
            if ((in_right_current_sample > current_limit_r)
                || (in_left_current_sample > current_limit_r)) begin
              oc_nxt = 1'b1;
            end
          end
        end
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          // (avg - a) * 100 / (b - a)
          num_nxt = mul100($signed({{(DIV_W-DEN_W){avg_off[DEN_W-1]}}, avg_off}));
          den_nxt = {1'b0, map_b} - {1'b0, map_a};
        end
      end
      ST_MAP1: begin
        if (div_rsp.done) begin
          // (phys - window low) * 100 / (window high - window low)
          num_nxt = mul100($signed({{(DIV_W-PCT_W-1){phys_off[PCT_W]}}, phys_off}));
          den_nxt = {{(DEN_W-PCT_W-1){win_span[PCT_W]}}, win_span};
        end
      end
      ST_MAP2: begin
        // deadband of one percent around the held position
        if (div_rsp.done && ((move > $signed((PCT_W+1)'(1)))
                             || (move < -$signed((PCT_W+1)'(1))))) begin
          held_nxt = disp;
        end
      end
      default: ;
    endcase
  end

  // result register: a waiting result is replaced only as it is taken
  always_comb begin
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      estop_r     <= 1'b0;
      oc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      estop_r     <= estop_nxt;
      oc_r        <= oc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    if (emit_load) begin
      out_pos_r   <= held_r;
      out_estop_r <= estop_r;
      out_oc_r    <= oc_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_position_percent = out_pos_r;
  assign out_estop_pressed    = out_estop_r;
  assign out_overcurrent      = out_oc_r;

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for actuator_position_sense_conditioner
// depends on apsc_pkg and the conditioner rtl; a directed table runs first, then random phases
`timescale 1ns / 1ps

module testbench;
  import apsc_pkg::*;

  // item kinds on in_action
  localparam logic ACT_POT    = 1'b0;
  localparam logic ACT_STATUS = 1'b1;

  localparam int ADC_MAX        = (1 << ADC_BITS) - 1;
  localparam int DIRECTED_ROWS  = 22;
  localparam int FIXED_PHASES   = 6;
  localparam int PHASES         = 11;
  localparam int PHASE_ITEMS    = 148;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct packed {
    logic                action;
    logic [ADC_BITS-1:0] pot_sample;
    logic                motor_moving;
    logic [ADC_BITS-1:0] right_current;
    logic [ADC_BITS-1:0] left_current;
    logic                estop_pin;
  } sense_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] position;
    logic             estop;
    logic             overcurrent;
  } reading_t;

  // one directed row: the item, then the result typed in where it is obvious
  typedef struct packed {
    logic                action;
    logic [ADC_BITS-1:0] pot_sample;
    logic                motor_moving;
    logic [ADC_BITS-1:0] right_current;
    logic [ADC_BITS-1:0] left_current;
    logic                estop_pin;
    logic                typed;
    logic [PCT_W-1:0]    position;
    logic                estop;
    logic                overcurrent;
  } dir_row_t;

  // one full set of register values, in the width of the write port
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pot_lo;
    logic [CFG_DATA_W-1:0] pot_hi;
    logic [CFG_DATA_W-1:0] reversed;
    logic [CFG_DATA_W-1:0] win_lo;
    logic [CFG_DATA_W-1:0] win_hi;
    logic [CFG_DATA_W-1:0] current_limit;
    logic [CFG_DATA_W-1:0] estop_low;
  } reg_set_t;

  // directed table, run at reset register values
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // pot item before any status item: stop flag still reads zero
    '{ACT_POT,    12'd0,    1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
    // pin high with low-active polarity: not pressed
    '{ACT_STATUS, 12'd0,    1'b0, 12'd0,    12'd0,    1'b1, 1'b1, 7'd0, 1'b0, 1'b0},
    // pin low: pressed; both currents exactly at the limit do not trip
    '{ACT_STATUS, 12'd0,    1'b0, 12'd4095, 12'd4095, 1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    // full-scale samples while stopped only accumulate
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b1, 7'd0, 1'b1, 1'b0},
    // tenth sample with the motor moving closes the group
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    // moving samples inside a group leave the position alone
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{ACT_POT,    12'd4095, 1'b1, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    // group closes while stopped: average dropped, position holds
    '{ACT_POT,    12'd4095, 1'b0, 12'd0,    12'd0,    1'b0, 1'b0, 7'd0, 1'b0, 1'b0}
  };

  // register settings of the first phases; later phases draw their own
  localparam reg_set_t FIXED_SETS [FIXED_PHASES] = '{
    // reversed travel, stop pin active high
    '{12'd0,    12'd4095, 12'd1, 12'd0,   12'd100, 12'd4095, 12'd0},
    // pot ends swapped, narrow window
    '{12'd4095, 12'd0,    12'd0, 12'd20,  12'd80,  12'd3000, 12'd1},
    // pot range zero: position must hold
    '{12'd1000, 12'd1000, 12'd1, 12'd0,   12'd100, 12'd2048, 12'd0},
    // window range zero: position must hold
    '{12'd500,  12'd3500, 12'd0, 12'd50,  12'd50,  12'd4095, 12'd1},
    // window limits inverted, low one above 100
    '{12'd300,  12'd3800, 12'd1, 12'd127, 12'd0,   12'd1,    12'd1},
    // one-count pot span, window running past 100
    '{12'd0,    12'd1,    12'd0, 12'd100, 12'd127, 12'd0,    12'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = 1'b0;
  logic [ADC_BITS-1:0]   in_pot_sample = '0;
  logic                  in_motor_moving = 1'b0;
  logic [ADC_BITS-1:0]   in_right_current_sample = '0;
  logic [ADC_BITS-1:0]   in_left_current_sample = '0;
  logic                  in_estop_pin = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PCT_W-1:0]      out_position_percent;
  logic                  out_estop_pressed;
  logic                  out_overcurrent;

  actuator_position_sense_conditioner dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor state: register copies and the block's own state
  // ---------------------------------------------------------------------
  logic [ADC_BITS-1:0] cfg_pot_lo    = RST_POT_ADC_LOW;
  logic [ADC_BITS-1:0] cfg_pot_hi    = RST_POT_ADC_HIGH;
  logic                cfg_reversed  = 1'b0;
  logic [PCT_W-1:0]    cfg_win_lo    = RST_WIN_LOW;
  logic [PCT_W-1:0]    cfg_win_hi    = RST_WIN_HIGH;
  logic [ADC_BITS-1:0] cfg_limit     = RST_CURRENT_LIMIT;
  logic                cfg_estop_low = 1'b1;

  logic [SUM_W-1:0]    pot_sum       = '0;
  logic [CNT_W-1:0]    pot_count     = '0;
  logic [PCT_W-1:0]    held_position = '0;
  logic                estop_flag    = 1'b0;
  logic                overcurrent_latch = 1'b0;

  // results still owed by the block, oldest first
  reading_t readings_due [$];
  int       mismatch_count = 0;
  int       idle_cycles = 0;

  // linear map of x from a..b onto 0..100, integer divide truncating toward zero
  function automatic int scale_pct(input int x, input int a, input int b);
    return ((x - a) * 100) / (b - a);
  endfunction

  function automatic int saturate_pct(input int v);
    if (v < 0) begin
      return 0;
    end
    if (v > 100) begin
      return 100;
    end
    return v;
  endfunction

  // advance the predictor by one accepted item and return the result it owes
  function automatic reading_t predict_reading(input sense_item_t it);
    int       avg, lo, hi, wl, wh, phys, disp, diff;
    reading_t r;
    lo = int'(cfg_pot_lo);
    hi = int'(cfg_pot_hi);
    wl = int'(cfg_win_lo);
    wh = int'(cfg_win_hi);
    if (it.action == ACT_POT) begin
      pot_sum = pot_sum + SUM_W'(it.pot_sample);
      pot_count = pot_count + CNT_W'(1);
      if (int'(pot_count) >= SAMPLES_PER_AVERAGE) begin
        avg = int'(pot_sum) / SAMPLES_PER_AVERAGE;
        pot_sum = '0;
        pot_count = '0;
        // stopped motor or a zero-width range leaves the position alone
        if (it.motor_moving && lo != hi && wl != wh) begin
          phys = saturate_pct(cfg_reversed ? scale_pct(avg, hi, lo) : scale_pct(avg, lo, hi));
          disp = saturate_pct(scale_pct(phys, wl, wh));
          diff = disp - int'(held_position);
          // deadband of one percent
          if (diff > 1 || diff < -1) begin
            held_position = disp[PCT_W-1:0];
          end
        end
      end
    end else begin
      estop_flag = cfg_estop_low ? ~it.estop_pin : it.estop_pin;
      if (it.right_current > cfg_limit || it.left_current > cfg_limit) begin
        overcurrent_latch = 1'b1;
      end
    end
    r.position = held_position;
    r.estop = estop_flag;
    r.overcurrent = overcurrent_latch;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // sender gap: mostly none or short, now and then a long one
  function automatic int sender_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 60);
  endfunction

  // adc count with a fair share of both extremes
  function automatic logic [ADC_BITS-1:0] pick_adc();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      return '0;
    end
    if (r < 4) begin
      return ADC_MAX[ADC_BITS-1:0];
    end
    return ADC_BITS'($urandom_range(0, ADC_MAX));
  endfunction

  // current reading that stays at or under the limit, often right on it
  function automatic logic [ADC_BITS-1:0] current_within(input logic [ADC_BITS-1:0] lim);
    if ($urandom_range(0, 3) == 0) begin
      return lim;
    end
    return ADC_BITS'($urandom_range(0, lim));
  endfunction

  // random register set; narrow registers sometimes get junk in the upper bits
  function automatic reg_set_t random_regs();
    reg_set_t s;
    s.pot_lo = pick_adc();
    s.pot_hi = ($urandom_range(0, 6) == 0) ? s.pot_lo : pick_adc();
    s.reversed = CFG_DATA_W'($urandom_range(0, ADC_MAX));
    s.win_lo = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, ADC_MAX)
                                                        : $urandom_range(0, 100));
    s.win_hi = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, ADC_MAX)
                                                        : $urandom_range(0, 100));
    if ($urandom_range(0, 9) == 0) begin
      s.win_hi = s.win_lo;
    end
    s.current_limit = pick_adc();
    s.estop_low = CFG_DATA_W'($urandom_range(0, ADC_MAX));
    return s;
  endfunction

  // drive one item from the falling edge, hold it until taken, then record its result
  task automatic send_item(input sense_item_t it, input int gap, input bit typed,
                           input reading_t typed_want);
    reading_t want;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= it.action;
    in_pot_sample <= it.pot_sample;
    in_motor_moving <= it.motor_moving;
    in_right_current_sample <= it.right_current;
    in_left_current_sample <= it.left_current;
    in_estop_pin <= it.estop_pin;
    do @(posedge clk); while (in_ready !== 1'b1);
    want = predict_reading(it);
    // the predictor always runs so its state keeps up with typed rows
    if (typed) begin
      want = typed_want;
    end
    readings_due.push_back(want);
  endtask

  // stop sending and wait for every owed result
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_POT_ADC_LOW:      cfg_pot_lo = data[ADC_BITS-1:0];
      REG_POT_ADC_HIGH:     cfg_pot_hi = data[ADC_BITS-1:0];
      REG_POT_REVERSED:     cfg_reversed = data[0];
      REG_WIN_LOW_PCT:      cfg_win_lo = data[PCT_W-1:0];
      REG_WIN_HIGH_PCT:     cfg_win_hi = data[PCT_W-1:0];
      REG_CURRENT_LIMIT:    cfg_limit = data[ADC_BITS-1:0];
      REG_ESTOP_LOW_ACTIVE: cfg_estop_low = data[0];
      default: ;
    endcase
  endtask

  // back-to-back writes of every register, then release the write enable
  task automatic program_regs(input reg_set_t s);
    write_reg(REG_POT_ADC_LOW, s.pot_lo);
    write_reg(REG_POT_ADC_HIGH, s.pot_hi);
    write_reg(REG_POT_REVERSED, s.reversed);
    write_reg(REG_WIN_LOW_PCT, s.win_lo);
    write_reg(REG_WIN_HIGH_PCT, s.win_hi);
    write_reg(REG_CURRENT_LIMIT, s.current_limit);
    write_reg(REG_ESTOP_LOW_ACTIVE, s.estop_low);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: mostly pot groups around a target so averages land in range,
  // some status items; currents stay at or under the limit unless tripping is allowed
  task automatic run_phase(input bit trip_ok);
    sense_item_t it;
    reading_t    none;
    int          target, sample, lo_b, hi_b, r;
    bit          burst;
    none = '0;
    target = ADC_MAX / 2;
    burst = 1'b0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // stretches with no sender gaps
      if (n % 40 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      // now and then let the block drain completely before the next item
      if ($urandom_range(0, 99) == 0) begin
        hold_until_drained();
      end
      it.pot_sample = ADC_BITS'($urandom_range(0, ADC_MAX));
      it.motor_moving = ($urandom_range(0, 3) != 0);
      it.right_current = ADC_BITS'($urandom_range(0, ADC_MAX));
      it.left_current = ADC_BITS'($urandom_range(0, ADC_MAX));
      it.estop_pin = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 80) begin
        it.action = ACT_POT;
        // new target at each group start; sometimes keep it to hit the deadband
        if (pot_count == '0) begin
          r = $urandom_range(0, 99);
          lo_b = int'((cfg_pot_lo < cfg_pot_hi) ? cfg_pot_lo : cfg_pot_hi);
          hi_b = int'((cfg_pot_lo < cfg_pot_hi) ? cfg_pot_hi : cfg_pot_lo);
          if (r < 10) begin
            target = 0;
          end else if (r < 20) begin
            target = ADC_MAX;
          end else if (r < 75) begin
            target = int'($urandom_range(lo_b, hi_b));
          end else if (r < 90) begin
            target = int'($urandom_range(0, ADC_MAX));
          end
        end
        sample = target + int'($urandom_range(0, 16)) - 8;
        if (sample < 0) begin
          sample = 0;
        end else if (sample > ADC_MAX) begin
          sample = ADC_MAX;
        end
        // a few fully random samples as noise
        if ($urandom_range(0, 9) != 0) begin
          it.pot_sample = sample[ADC_BITS-1:0];
        end
      end else begin
        it.action = ACT_STATUS;
        if (!trip_ok) begin
          it.right_current = current_within(cfg_limit);
          it.left_current = current_within(cfg_limit);
        end
      end
      send_item(it, sender_gap(burst), 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: random back-pressure, some stretches always ready
  // ---------------------------------------------------------------------
  initial begin
    int hold, mode_left, r;
    bit level, eager;
    hold = 0;
    mode_left = 0;
    level = 1'b0;
    eager = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        eager = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (eager || r < 65) begin
          level = 1'b1;
          hold = $urandom_range(1, 8);
        end else if (r < 95) begin
          level = 1'b0;
          hold = $urandom_range(1, 4);
        end else begin
          level = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
      hold--;
      out_ready <= level;
    end
  end

  // compare each taken result with the oldest one owed
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (readings_due.size() == 0) begin
        $error("result item with none expected: position_percent %0d", out_position_percent);
        mismatch_count++;
      end else begin
        want = readings_due.pop_front();
        if (out_position_percent !== want.position) begin
          $error("position_percent: expected %0d, actual %0d", want.position,
                 out_position_percent);
          mismatch_count++;
        end
        if (out_estop_pressed !== want.estop) begin
          $error("estop_pressed: expected %0d, actual %0d", want.estop, out_estop_pressed);
          mismatch_count++;
        end
        if (out_overcurrent !== want.overcurrent) begin
          $error("overcurrent: expected %0d, actual %0d", want.overcurrent, out_overcurrent);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long with no item moving on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    sense_item_t it;
    reading_t    want;
    reg_set_t    regs;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at reset register values
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      it.action = DIRECTED[i].action;
      it.pot_sample = DIRECTED[i].pot_sample;
      it.motor_moving = DIRECTED[i].motor_moving;
      it.right_current = DIRECTED[i].right_current;
      it.left_current = DIRECTED[i].left_current;
      it.estop_pin = DIRECTED[i].estop_pin;
      want.position = DIRECTED[i].position;
      want.estop = DIRECTED[i].estop;
      want.overcurrent = DIRECTED[i].overcurrent;
      send_item(it, sender_gap(1'b0), DIRECTED[i].typed, want);
    end

    // random phases, registers rewritten only with the block idle;
    // overcurrent only trips in the last phase since nothing but reset clears it
    for (int p = 0; p < PHASES; p++) begin
      hold_until_drained();
      regs = (p < FIXED_PHASES) ? FIXED_SETS[p] : random_regs();
      program_regs(regs);
      run_phase(p == PHASES - 1);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
